// ===== src/lsac_pkg.sv =====
// Shared types and constants for the set-associative LRU cache lookup.
`timescale 1ns / 1ps

package lsac_pkg;

  localparam int TAG_W   = 48;
  localparam int STAMP_W = 64;
  localparam int CNT_W   = 48;
  localparam int ADDR_W  = 48;
  localparam int CFG_W   = 4;
  localparam int OUT_W   = 160;

  localparam logic [3:0] OFFSET_MAX = 4'd12;

  // configuration register indexes
  localparam logic CFG_INDEX_BITS  = 1'b0;
  localparam logic CFG_OFFSET_BITS = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_SCAN,
    ST_WRITE
  } state_t;

  typedef struct packed {
    logic               valid;
    logic [TAG_W-1:0]   tag;
    logic [STAMP_W-1:0] stamp;
  } line_t;

  typedef struct packed {
    logic clear_step;
    logic accept;
    logic look;
    logic scan_step;
    logic write;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic need_scan;
    logic scan_last;
  } dp_status_t;

endpackage

// ===== src/lsac_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module lsac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/lsac_ctrl.sv =====
// Controller state machine: clearing pass, lookup sequencing, output handshake.
`timescale 1ns / 1ps

module lsac_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  input  lsac_pkg::dp_status_t  status,
  output lsac_pkg::ctrl_cmd_t   cmd
);

  lsac_pkg::state_t state, state_next;
  logic out_free;

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= lsac_pkg::ST_CLEAR;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.write) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      lsac_pkg::ST_CLEAR: if (status.clear_last) state_next = lsac_pkg::ST_IDLE;
      lsac_pkg::ST_IDLE:  if (s_tvalid) state_next = lsac_pkg::ST_LOOK;
      lsac_pkg::ST_LOOK: begin
        state_next = status.need_scan ? lsac_pkg::ST_SCAN : lsac_pkg::ST_WRITE;
      end
      lsac_pkg::ST_SCAN:  if (status.scan_last) state_next = lsac_pkg::ST_WRITE;
      lsac_pkg::ST_WRITE: if (out_free) state_next = lsac_pkg::ST_IDLE;
      default:            state_next = lsac_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    s_tready       = 1'b0;
    cmd            = '0;
    case (state)
      lsac_pkg::ST_CLEAR: cmd.clear_step = 1'b1;
      lsac_pkg::ST_IDLE: begin
        s_tready   = 1'b1;
        cmd.accept = s_tvalid;
      end
      lsac_pkg::ST_LOOK:  cmd.look = 1'b1;
      lsac_pkg::ST_SCAN:  cmd.scan_step = 1'b1;
      lsac_pkg::ST_WRITE: cmd.write = out_free;
      default: ;
    endcase
  end

endmodule

// ===== src/lsac_dp.sv =====
// Datapath: address split, set memory, tag match, LRU scan, counters, result word.
`timescale 1ns / 1ps

module lsac_dp #(
  parameter int WAYS      = 8,
  parameter int SETS_MAX  = 256,
  parameter int ADDR_BITS = 48
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  input  logic [0:0]                      cfg_index,
  input  logic [lsac_pkg::CFG_W-1:0]      cfg_data,
  input  logic [lsac_pkg::ADDR_W-1:0]     s_tdata,
  output logic [lsac_pkg::OUT_W-1:0]      m_tdata,
  input  lsac_pkg::ctrl_cmd_t             cmd,
  output lsac_pkg::dp_status_t            status
);

  localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int SET_W  = (SETS_MAX > 1) ? $clog2(SETS_MAX) : 1;
  localparam int IB_MAX = $clog2(SETS_MAX + 1) - 1;
  localparam int ROW_W  = WAYS * $bits(lsac_pkg::line_t);
  localparam logic [lsac_pkg::ADDR_W-1:0] AMASK =
    (ADDR_BITS >= lsac_pkg::ADDR_W) ? '1
      : ((lsac_pkg::ADDR_W)'(1) << ADDR_BITS) - (lsac_pkg::ADDR_W)'(1);

  // configuration
  logic [3:0] index_bits, offset_bits;

  always_ff @(posedge clk) begin
    if (rst) begin
      index_bits  <= 4'd8;
      offset_bits <= 4'd6;
    end else if (cfg_valid) begin
      if (cfg_index == lsac_pkg::CFG_INDEX_BITS) index_bits <= cfg_data;
      if (cfg_index == lsac_pkg::CFG_OFFSET_BITS) offset_bits <= cfg_data;
    end
  end

  // address split
  logic [3:0]                    ob, ib;
  logic [4:0]                    tag_sh;
  logic [lsac_pkg::ADDR_W-1:0]   addr_m, set_full;
  logic [SET_W-1:0]              set_in;
  logic [lsac_pkg::TAG_W-1:0]    tag_in;

  always_comb begin
    ob       = (offset_bits > lsac_pkg::OFFSET_MAX) ? lsac_pkg::OFFSET_MAX : offset_bits;
    ib       = (index_bits > 4'(IB_MAX)) ? 4'(IB_MAX) : index_bits;
    addr_m   = s_tdata & AMASK;
    set_full = (addr_m >> ob) & ~({lsac_pkg::ADDR_W{1'b1}} << ib);
    set_in   = set_full[SET_W-1:0];
    tag_sh   = {1'b0, ob} + {1'b0, ib};
    tag_in   = addr_m >> tag_sh;
  end

  logic [SET_W-1:0]           set_q;
  logic [lsac_pkg::TAG_W-1:0] tag_q;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      set_q <= set_in;
      tag_q <= tag_in;
    end
  end

  // clearing pass counter
  logic [SET_W-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_step) begin
      clr_addr <= clr_addr + SET_W'(1);
    end
  end

  assign status.clear_last = (clr_addr == SET_W'(SETS_MAX - 1));

  // set memory, one row holds every way of a set
  logic [ROW_W-1:0]                    ram_rdata, ram_wdata;
  lsac_pkg::line_t [WAYS-1:0]          row_rd, row_wr;

  assign row_rd    = ram_rdata;
  assign ram_wdata = cmd.clear_step ? '0 : row_wr;

  lsac_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SETS_MAX)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.clear_step || cmd.write),
    .waddr (cmd.clear_step ? clr_addr : set_q),
    .wdata (ram_wdata),
    .re    (cmd.accept),
    .raddr (set_in),
    .rdata (ram_rdata)
  );

  // tag match and first empty way, lowest way wins
  logic             lk_hit, lk_empty;
  logic [WAY_W-1:0] lk_hway, lk_eway;

  always_comb begin
    lk_hit   = 1'b0;
    lk_empty = 1'b0;
    lk_hway  = '0;
    lk_eway  = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (row_rd[w].valid && row_rd[w].tag == tag_q) begin
        lk_hit  = 1'b1;
        lk_hway = WAY_W'(w);
      end
      if (!row_rd[w].valid) begin
        lk_empty = 1'b1;
        lk_eway  = WAY_W'(w);
      end
    end
  end

  assign status.need_scan = !lk_hit && !lk_empty && (WAYS > 1);

  logic                         hit_q, empty_q;
  logic [WAY_W-1:0]             hway_q, eway_q, best_way, scan_k;
  logic [lsac_pkg::STAMP_W-1:0] best_stamp;

  // LRU scan: one way compared per cycle
  always_ff @(posedge clk) begin
    if (cmd.look) begin
      hit_q      <= lk_hit;
      empty_q    <= lk_empty;
      hway_q     <= lk_hway;
      eway_q     <= lk_eway;
      best_way   <= '0;
      best_stamp <= row_rd[0].stamp;
      scan_k     <= WAY_W'(1);
    end else if (cmd.scan_step) begin
      if (row_rd[scan_k].stamp < best_stamp) begin
        best_way   <= scan_k;
        best_stamp <= row_rd[scan_k].stamp;
      end
      scan_k <= scan_k + WAY_W'(1);
    end
  end

  assign status.scan_last = (scan_k == WAY_W'(WAYS - 1));

  // write back and result
  logic [WAY_W-1:0]             fin_way;
  logic                         evict;
  logic [lsac_pkg::STAMP_W-1:0] tick;
  logic [lsac_pkg::CNT_W-1:0]   hits, misses;

  always_comb begin
    fin_way = hit_q ? hway_q : (empty_q ? eway_q : best_way);
    evict   = !hit_q && !empty_q;
    row_wr  = row_rd;
    row_wr[fin_way] = '{valid: 1'b1, tag: tag_q, stamp: tick};
  end

  logic                         r_hit, r_filled, r_evict;
  logic [SET_W-1:0]             r_set;
  logic [WAY_W-1:0]             r_way;
  logic [lsac_pkg::TAG_W-1:0]   r_victim;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick   <= '0;
      hits   <= '0;
      misses <= '0;
    end else if (cmd.write) begin
      tick <= tick + lsac_pkg::STAMP_W'(1);
      if (hit_q && hits != '1) hits <= hits + lsac_pkg::CNT_W'(1);
      if (!hit_q && misses != '1) misses <= misses + lsac_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      r_hit    <= hit_q;
      r_set    <= set_q;
      r_way    <= fin_way;
      r_filled <= !hit_q && empty_q;
      r_evict  <= evict;
      r_victim <= evict ? row_rd[fin_way].tag : '0;
    end
  end

  logic [WAY_W+2:0] way_ext;
  logic [SET_W+7:0] set_ext;

  assign way_ext = (WAY_W + 3)'(r_way);
  assign set_ext = (SET_W + 8)'(r_set);
  assign m_tdata = {2'b00, misses, hits, r_victim, r_evict, r_filled,
                    way_ext[2:0], set_ext[7:0], r_hit};

endmodule

// ===== src/lru_set_assoc_cache_lookup.sv =====
// Top level of the set-associative cache lookup with LRU replacement.
`timescale 1ns / 1ps

// Each input word is one byte address; each output word reports hit or miss, the set,
// the way hit, filled or replaced, the evicted tag and the running hit and miss counts.
// The address splits into offset (offset_bits, capped at 12), set (index_bits, capped
// so the set count fits SETS_MAX) and tag. A lookup that hits or fills an empty way
// runs through accept with set read, tag compare and write back; one that must evict
// adds the LRU scan before write back, comparing one way's use stamp per cycle on a
// single shared comparator. One address is in flight at a time; a finished result
// waits in the output register while the next address is taken. After reset a
// clearing pass zeroes every row of the set memory before the first address is
// accepted; configuration writes are taken at any time.
module lru_set_assoc_cache_lookup #(
  parameter int WAYS      = 8,
  parameter int SETS_MAX  = 256,
  parameter int ADDR_BITS = 48
) (
  input  logic         clk,
  input  logic         rst,
  // configuration write channel
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [0:0]   cfg_index,
  input  logic [3:0]   cfg_data,
  // address words in
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [47:0]  s_tdata,   // address[47:0]
  // result words out
  output logic         m_tvalid,
  input  logic         m_tready,
  // hit[0], set_index[8:1], way[11:9], filled_empty[12], evicted[13],
  // victim_tag[61:14], hit_count[109:62], miss_count[157:110], zero[159:158]
  output logic [159:0] m_tdata
);

  lsac_pkg::ctrl_cmd_t  cmd;
  lsac_pkg::dp_status_t status;

  // user writes registers only between lookups (unchecked); cfg has no back-pressure
  assign cfg_ready = 1'b1;

  lsac_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  lsac_dp #(
    .WAYS      (WAYS),
    .SETS_MAX  (SETS_MAX),
    .ADDR_BITS (ADDR_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .m_tdata   (m_tdata),
    .cmd       (cmd),
    .status    (status)
  );

  // a new result appears only after a write-back command
  a_rise_after_write: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(cmd.write))
    else $error("result raised without write-back");

  // a hit never reports an eviction or a fill
  a_hit_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> !m_tdata[12] && !m_tdata[13])
    else $error("hit flagged as fill or eviction");

  // victim tag is zero unless a line was evicted
  a_victim_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[13] |-> m_tdata[61:14] == '0)
    else $error("victim tag without eviction");

  // input is never taken while an LRU scan or a write-back is under way
  a_no_accept_in_write: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !cmd.write && !cmd.scan_step)
    else $error("input ready during lookup");

endmodule

// ===== tb/sv/lsac_checker.sv =====
// Checker for the cache lookup: predicts each result word from the addresses and compares.
`timescale 1ns / 1ps

module lsac_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [0:0]   cfg_index,
  input  logic [3:0]   cfg_data,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [47:0]  s_tdata,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [159:0] m_tdata,
  output int           fail_count,
  output int           pending
);

  localparam int NWAYS = 8;
  localparam int NSETS = 256;
  localparam logic [47:0] CNT_TOP = '1;

  typedef struct packed {
    logic [47:0] miss_count;
    logic [47:0] hit_count;
    logic [47:0] victim_tag;
    logic        evicted;
    logic        filled_empty;
    logic [2:0]  way;
    logic [7:0]  set_index;
    logic        hit;
  } lookup_res_t;

  logic [3:0]  idx_bits, off_bits;
  logic        v_mem [NSETS*NWAYS];
  logic [47:0] tag_mem [NSETS*NWAYS];
  logic [63:0] stamp_mem [NSETS*NWAYS];
  logic [63:0] tick;
  logic [47:0] hits, misses;
  lookup_res_t lookups_due[$];

  function automatic lookup_res_t predict_lookup(input logic [47:0] addr);
    lookup_res_t r;
    int ib, ob, base, w;
    logic [47:0] set, tag;
    logic found;
    ib = idx_bits;
    while (ib > 0 && (1 << ib) > NSETS) ib--;
    ob = (off_bits > lsac_pkg::OFFSET_MAX) ? lsac_pkg::OFFSET_MAX : off_bits;
    set = (addr >> ob) & ((48'd1 << ib) - 48'd1);
    tag = addr >> (ob + ib);
    base = int'(set) * NWAYS;
    r = '0;
    r.set_index = set[7:0];
    found = 0;
    for (w = 0; w < NWAYS; w++)
      if (!found && v_mem[base+w] && tag_mem[base+w] == tag) begin
        found = 1; r.hit = 1; r.way = 3'(w);
      end
    if (found) begin
      stamp_mem[base+r.way] = tick;
      if (hits != CNT_TOP) hits++;
    end else begin
      if (misses != CNT_TOP) misses++;
      for (w = 0; w < NWAYS; w++)
        if (!r.filled_empty && !v_mem[base+w]) begin
          r.filled_empty = 1; r.way = 3'(w);
        end
      if (!r.filled_empty) begin
        r.way = 0;
        for (w = 1; w < NWAYS; w++)
          if (stamp_mem[base+w] < stamp_mem[base+r.way]) r.way = 3'(w);
        r.evicted = 1;
        r.victim_tag = tag_mem[base+r.way];
      end
      v_mem[base+r.way] = 1;
      tag_mem[base+r.way] = tag;
      stamp_mem[base+r.way] = tick;
    end
    tick++;
    r.hit_count = hits;
    r.miss_count = misses;
    return r;
  endfunction

  assign pending = lookups_due.size();

  always @(posedge clk) begin
    lookup_res_t want, got;
    int errs;
    errs = 0;
    if (rst) begin
      idx_bits <= 4'd8; off_bits <= 4'd6;
      for (int i = 0; i < NSETS*NWAYS; i++) v_mem[i] = 0;
      tick = 0; hits = 0; misses = 0;
      lookups_due.delete();
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == lsac_pkg::CFG_INDEX_BITS) idx_bits <= cfg_data;
        else off_bits <= cfg_data;
      end
      if (s_tvalid && s_tready) lookups_due.push_back(predict_lookup(s_tdata));
      if (m_tvalid && m_tready) begin
        got = m_tdata[157:0];
        if (lookups_due.size() == 0) begin
          $error("result word with nothing expected");
          errs++;
        end else begin
          want = lookups_due.pop_front();
          if (got !== want) begin
            errs++;
            if (got.hit !== want.hit)
              $error("hit: exp %0d got %0d", want.hit, got.hit);
            if (got.set_index !== want.set_index)
              $error("set_index: exp %0d got %0d", want.set_index, got.set_index);
            if (got.way !== want.way)
              $error("way: exp %0d got %0d", want.way, got.way);
            if (got.filled_empty !== want.filled_empty)
              $error("filled_empty: exp %0d got %0d", want.filled_empty, got.filled_empty);
            if (got.evicted !== want.evicted)
              $error("evicted: exp %0d got %0d", want.evicted, got.evicted);
            if (got.victim_tag !== want.victim_tag)
              $error("victim_tag: exp %h got %h", want.victim_tag, got.victim_tag);
            if (got.hit_count !== want.hit_count)
              $error("hit_count: exp %0d got %0d", want.hit_count, got.hit_count);
            if (got.miss_count !== want.miss_count)
              $error("miss_count: exp %0d got %0d", want.miss_count, got.miss_count);
          end
        end
        if (m_tdata[159:158] !== 2'b00) begin
          $error("pad bits: exp 0 got %b", m_tdata[159:158]);
          errs++;
        end
      end
      fail_count <= fail_count + errs;
    end
  end
endmodule

// ===== tb/sv/tb.sv =====
// Testbench top: drives addresses and register writes into the cache lookup, gives the verdict.
`timescale 1ns / 1ps

module tb;

  logic         clk = 0;
  logic         rst = 1;
  logic         cfg_valid = 0;
  logic         cfg_ready;
  logic [0:0]   cfg_index = lsac_pkg::CFG_INDEX_BITS;
  logic [3:0]   cfg_data = '0;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [47:0]  s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [159:0] m_tdata;
  int           fail_count, pending;
  int           send_idle_pct = 0, recv_idle_pct = 0;

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  lru_set_assoc_cache_lookup uut (.*);
  lsac_checker chk (.*);

  // receiver: random back-pressure at the current rate
  always @(posedge clk)
    m_tready <= ($urandom_range(99) >= recv_idle_pct);

  // one register write, only while nothing is in flight
  task automatic write_reg(input logic [0:0] idx, input logic [3:0] val);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  // one address word, with a random gap in front; valid stays up for the next word
  task automatic send_addr(input logic [47:0] addr);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1; s_tdata <= addr;
    do @(posedge clk); while (!s_tready);
  endtask

  // stop sending and wait until every expected result has come
  task automatic wait_empty();
    s_tvalid <= 0;
    do @(posedge clk); while (pending != 0);
  endtask

  // let the pipe empty, then leave the bus idle before going on
  task automatic drain();
    wait_empty();
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [47:0] rand_addr();
    return 48'({$urandom, $urandom});
  endfunction

  // addresses mostly confined to a few tags and sets so hits and evictions are common
  function automatic logic [47:0] hot_addr(input int ob, input int ib);
    logic [47:0] a;
    a = 48'($urandom_range(15)) << (ob + ib);
    a |= 48'($urandom_range(3)) << ob;
    a |= 48'($urandom) & ((48'd1 << ob) - 48'd1);
    if ($urandom_range(15) == 0) a = rand_addr();
    return a;
  endfunction

  initial begin
    int ob, ib;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: field extremes at reset split, then hits, fills and evictions in one set
    send_addr('0);
    send_addr('1);
    send_addr('0);
    send_addr(48'h5555_5555_5555);
    send_addr(48'hAAAA_AAAA_AAAA);
    for (int t = 0; t < 10; t++) send_addr(48'(t) << 14);
    send_addr(48'h0);
    send_addr(48'd9 << 14);
    drain();
    // change of split keeps old lines: may find duplicate tags
    write_reg(lsac_pkg::CFG_INDEX_BITS, 4'd0);
    write_reg(lsac_pkg::CFG_OFFSET_BITS, 4'd15);
    send_addr('0);
    send_addr('1);
    send_addr(48'd1 << 14);
    drain();
    write_reg(lsac_pkg::CFG_INDEX_BITS, 4'd15);
    write_reg(lsac_pkg::CFG_OFFSET_BITS, 4'd0);
    send_addr('1);
    send_addr(48'h123);
    drain();

    // random phases: three idling patterns, several register settings each
    for (int phase = 0; phase < 12; phase++) begin
      case (phase / 4)
        0: begin send_idle_pct = 26; recv_idle_pct = 48; end
        1: begin send_idle_pct = 48; recv_idle_pct = 26; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      ib = (phase % 4 == 0) ? 0 : (phase % 4 == 1) ? 15 : $urandom_range(15);
      ob = (phase % 4 == 0) ? 15 : (phase % 4 == 1) ? 0 : $urandom_range(15);
      write_reg(lsac_pkg::CFG_INDEX_BITS, 4'(ib));
      write_reg(lsac_pkg::CFG_OFFSET_BITS, 4'(ob));
      if (ib > 8) ib = 8;
      if (ob > 12) ob = 12;
      for (int n = 0; n < 150; n++) begin
        send_addr(($urandom_range(3) == 0) ? rand_addr() : hot_addr(ob, ib));
        if (n == 75) wait_empty();
      end
      drain();
    end

    if (fail_count == 0)
      $display("lru_set_assoc_cache_lookup verification clean");
    else
      $display("lru_set_assoc_cache_lookup verification failed");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("lru_set_assoc_cache_lookup verification failed");
    $finish;
  end
endmodule
